// ----- rtl/detection_decode_greedy_nms_assert.svh -----
// Assertion macros used by dgnms_back
`ifndef DETECTION_DECODE_GREEDY_NMS_ASSERT_SVH
`define DETECTION_DECODE_GREEDY_NMS_ASSERT_SVH

`define DGNMS_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("dgnms invariant violated");

`define DGNMS_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dgnms implication violated");

`endif

// ----- rtl/dgnms_pkg.sv -----
package dgnms_pkg;

	localparam int KEPT_DEPTH_DEF = 64;
	localparam int BOX_FIELDS = 5;
	localparam int BASKET_CLASSES = 7;
	localparam int MAX_CLASSES = 250;
	localparam int QUEUE_DEPTH = 4;
	localparam int CFG_W = 24;
	localparam int KEPT_W = 128;

	typedef enum logic [2:0] {
		CFG_CLASS_COUNT,
		CFG_MIN_OBJECTNESS,
		CFG_MIN_CONFIDENCE,
		CFG_MAX_OVERLAP,
		CFG_PAD_X,
		CFG_PAD_Y,
		CFG_INVERSE_SCALE,
		CFG_CAMERA_ID
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] element;
		logic               group_start;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] left_x;
		logic signed [31:0] top_y;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] box_width;
		logic signed [31:0] box_height;
		logic [7:0]         class_label;
		logic [16:0]        score;
		logic               in_basket;
		logic               picked;
		logic               store_full;
		logic [3:0]         source_camera;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  class_count;
		logic [16:0] min_objectness;
		logic [16:0] min_confidence;
		logic [16:0] max_overlap;
		logic [11:0] pad_x;
		logic [11:0] pad_y;
		logic [23:0] inverse_scale;
		logic [3:0]  camera_id;
	} cfg_t;

	typedef struct packed {
		logic [3:0][31:0] box;
		logic [31:0]      objectness;
		logic [31:0]      best;
		logic [7:0]       best_class;
		logic             group;
	} row_rec_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_OBJ, ST_CONF, ST_MX, ST_MY, ST_MW, ST_MH, ST_EDGE, ST_AREA,
		ST_RD, ST_LD, ST_OV, ST_IN, ST_AK, ST_U, ST_PL, ST_PH, ST_DONE, ST_EMIT
	} back_state_t;

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		logic signed [31:0] r;
		if (v > 68'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -68'sh0_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// ----- rtl/detection_decode_greedy_nms.sv -----
// Elements are taken one per cycle while the row queue is not full; a row's result
// comes later for each kept box that it is compared against. Rows that fail a
// threshold end early, at the objectness or confidence check, and give no result.
// A 4-entry row queue lets the element stream run on while the IoU walk over the
// kept-box memory (one entry read per pass) finishes earlier rows.
// Reset (arst_n, asynchronous, active low) restores the register defaults and empties the kept store.
module detection_decode_greedy_nms import dgnms_pkg::*; #(
	parameter int KEPT_DEPTH = KEPT_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cfg_t     cfg_q;
	logic     q_full, q_empty, push, pop;
	row_rec_t rec_in, rec_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.class_count    <= 8'd80;
			cfg_q.min_objectness <= 17'd26214;
			cfg_q.min_confidence <= 17'd32768;
			cfg_q.max_overlap    <= 17'd26214;
			cfg_q.pad_x          <= '0;
			cfg_q.pad_y          <= '0;
			cfg_q.inverse_scale  <= 24'd65536;
			cfg_q.camera_id      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_CLASS_COUNT:    cfg_q.class_count    <= cfg_data[7:0];
				CFG_MIN_OBJECTNESS: cfg_q.min_objectness <= cfg_data[16:0];
				CFG_MIN_CONFIDENCE: cfg_q.min_confidence <= cfg_data[16:0];
				CFG_MAX_OVERLAP:    cfg_q.max_overlap    <= cfg_data[16:0];
				CFG_PAD_X:          cfg_q.pad_x          <= cfg_data[11:0];
				CFG_PAD_Y:          cfg_q.pad_y          <= cfg_data[11:0];
				CFG_INVERSE_SCALE:  cfg_q.inverse_scale  <= cfg_data[23:0];
				CFG_CAMERA_ID:      cfg_q.camera_id      <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	dgnms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_full   (q_full),
		.push     (push),
		.rec      (rec_in)
	);

	dgnms_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (rec_in),
		.full   (q_full),
		.pop    (pop),
		.dout   (rec_out),
		.empty  (q_empty)
	);

	dgnms_back #(.KEPT_DEPTH(KEPT_DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.pop       (pop),
		.rec       (rec_out),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- rtl/dgnms_ram.sv -----
module dgnms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/dgnms_queue.sv -----
module dgnms_queue import dgnms_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  row_rec_t din,
	output logic     full,
	input  logic     pop,
	output row_rec_t dout,
	output logic     empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	row_rec_t       mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [PW:0]    cnt_q;

	assign full  = cnt_q == (PW+1)'(QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign dout  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ----- rtl/dgnms_front.sv -----
module dgnms_front import dgnms_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_data,
	input  logic     q_full,
	output logic     push,
	output row_rec_t rec
);

	logic [7:0]       pos_q;
	logic             grp_q;
	logic [3:0][31:0] box_q;
	logic [31:0]      obj_q, best_q;
	logic [7:0]       cls_q;

	logic             acc, fin;
	logic [7:0]       pos, cnt, last;
	logic [3:0][31:0] box_n;
	logic [31:0]      obj_n, best_n;
	logic [7:0]       cls_n;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;

	always_comb begin
		pos = in_data.group_start ? 8'd0 : pos_q;
		if (cfg.class_count == 8'd0)
			cnt = 8'd1;
		else if (cfg.class_count > 8'(MAX_CLASSES))
			cnt = 8'(MAX_CLASSES);
		else
			cnt = cfg.class_count;
		last = 8'(BOX_FIELDS - 1) + cnt;
		fin  = pos >= last;

		box_n  = box_q;
		obj_n  = obj_q;
		best_n = best_q;
		cls_n  = cls_q;
		if (pos < 8'd4)
			box_n[pos[1:0]] = in_data.element;
		else if (pos == 8'd4)
			obj_n = in_data.element;
		else if (pos == 8'(BOX_FIELDS)) begin
			best_n = in_data.element;
			cls_n  = 8'd0;
		end else if ($signed(in_data.element) > $signed(best_q)) begin
			best_n = in_data.element;
			cls_n  = pos - 8'(BOX_FIELDS);
		end

		push           = acc && fin;
		rec.box        = box_n;
		rec.objectness = obj_n;
		rec.best       = best_n;
		rec.best_class = cls_n;
		rec.group      = grp_q || in_data.group_start;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			box_q  <= box_n;
			obj_q  <= obj_n;
			best_q <= best_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			grp_q <= 1'b0;
			cls_q <= '0;
		end else if (acc) begin
			cls_q <= cls_n;
			if (fin) begin
				pos_q <= '0;
				grp_q <= 1'b0;
			end else begin
				pos_q <= pos + 8'd1;
				grp_q <= grp_q || in_data.group_start;
			end
		end
	end

endmodule

// ----- rtl/dgnms_back.sv -----
`include "detection_decode_greedy_nms_assert.svh"

module dgnms_back import dgnms_pkg::*; #(
	parameter int KEPT_DEPTH = KEPT_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_empty,
	output logic      pop,
	input  row_rec_t  rec,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int AW = (KEPT_DEPTH > 1) ? $clog2(KEPT_DEPTH) : 1;
	localparam int CW = $clog2(KEPT_DEPTH + 1);

	back_state_t         state_q, state_d;
	row_rec_t            rec_q;
	logic signed [67:0]  mul_q;
	logic signed [33:0]  ma, mb;
	logic [16:0]         score_q;
	logic signed [31:0]  cx_q, cy_q, w_q, h_q, l_q, t_q;
	logic [63:0]         aw_q, inter_q, uni_q;
	logic [32:0]         ox_q, oy_q;
	logic [30:0]         kwc_q, khc_q;
	logic [48:0]         plo_q;
	logic [CW-1:0]       k_q, kept_cnt_q;
	logic                pick_q, full_q, out_valid_q;
	out_item_t           out_q;

	logic                ram_we, slot_free, room, low_obj, low_conf, suppress;
	logic [KEPT_W-1:0]   rdata;
	logic [47:0]         sh;
	logic signed [33:0]  dx, dy, le, te;
	logic signed [31:0]  kl, kw, kt, kh;
	logic signed [32:0]  r1x, r2x, r1y, r2y, lox, hix, loy, hiy;
	logic signed [33:0]  dfx, dfy;

	assign slot_free = !out_valid_q || out_ready;
	assign room      = kept_cnt_q < CW'(KEPT_DEPTH);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign ram_we    = (state_q == ST_DONE) && pick_q && room;

	dgnms_ram #(.WIDTH(KEPT_W), .DEPTH(KEPT_DEPTH)) u_kept (
		.clk   (clk),
		.we    (ram_we),
		.waddr (kept_cnt_q[AW-1:0]),
		.wdata ({l_q, w_q, t_q, h_q}),
		.raddr (k_q[AW-1:0]),
		.rdata (rdata)
	);

	always_comb begin
		dx = $signed({{2{rec_q.box[0][31]}}, rec_q.box[0]}) - $signed({6'b0, cfg.pad_x, 16'b0});
		dy = $signed({{2{rec_q.box[1][31]}}, rec_q.box[1]}) - $signed({6'b0, cfg.pad_y, 16'b0});
		le = $signed({{2{cx_q[31]}}, cx_q}) - $signed({{3{w_q[31]}}, w_q[31:1]});
		te = $signed({{2{cy_q[31]}}, cy_q}) - $signed({{3{h_q[31]}}, h_q[31:1]});
		low_obj  = $signed({rec_q.objectness[31], rec_q.objectness})
			< $signed({16'b0, cfg.min_objectness});
		low_conf = mul_q < $signed({35'b0, cfg.min_confidence, 16'b0});
		sh       = mul_q[63:16];

		kl = rdata[127:96];
		kw = rdata[95:64];
		kt = rdata[63:32];
		kh = rdata[31:0];
		r1x = $signed({l_q[31], l_q}) + $signed({w_q[31], w_q});
		r2x = $signed({kl[31], kl}) + $signed({kw[31], kw});
		r1y = $signed({t_q[31], t_q}) + $signed({h_q[31], h_q});
		r2y = $signed({kt[31], kt}) + $signed({kh[31], kh});
		lox = (l_q > kl) ? $signed({l_q[31], l_q}) : $signed({kl[31], kl});
		loy = (t_q > kt) ? $signed({t_q[31], t_q}) : $signed({kt[31], kt});
		hix = (r1x < r2x) ? r1x : r2x;
		hiy = (r1y < r2y) ? r1y : r2y;
		dfx = $signed({hix[32], hix}) - $signed({lox[32], lox});
		dfy = $signed({hiy[32], hiy}) - $signed({loy[32], loy});

		suppress = {1'b0, inter_q, 16'b0} > ({mul_q[48:0], 32'b0} + {32'b0, plo_q});

		unique case (state_q)
			ST_OBJ: begin
				ma = {{2{rec_q.objectness[31]}}, rec_q.objectness};
				mb = {{2{rec_q.best[31]}}, rec_q.best};
			end
			ST_CONF: begin
				ma = dx;
				mb = {10'b0, cfg.inverse_scale};
			end
			ST_MX: begin
				ma = dy;
				mb = {10'b0, cfg.inverse_scale};
			end
			ST_MY: begin
				ma = {{2{rec_q.box[2][31]}}, rec_q.box[2]};
				mb = {10'b0, cfg.inverse_scale};
			end
			ST_MW: begin
				ma = {{2{rec_q.box[3][31]}}, rec_q.box[3]};
				mb = {10'b0, cfg.inverse_scale};
			end
			ST_EDGE: begin
				ma = w_q[31] ? '0 : {3'b0, w_q[30:0]};
				mb = h_q[31] ? '0 : {3'b0, h_q[30:0]};
			end
			ST_OV: begin
				ma = {1'b0, ox_q};
				mb = {1'b0, oy_q};
			end
			ST_IN: begin
				ma = {3'b0, kwc_q};
				mb = {3'b0, khc_q};
			end
			ST_U: begin
				ma = {2'b0, uni_q[31:0]};
				mb = {17'b0, cfg.max_overlap};
			end
			ST_PL: begin
				ma = {2'b0, uni_q[63:32]};
				mb = {17'b0, cfg.max_overlap};
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = ST_OBJ;
				end
			end
			ST_OBJ:  state_d = low_obj ? ST_IDLE : ST_CONF;
			ST_CONF: state_d = low_conf ? ST_IDLE : ST_MX;
			ST_MX:   state_d = ST_MY;
			ST_MY:   state_d = ST_MW;
			ST_MW:   state_d = ST_MH;
			ST_MH:   state_d = ST_EDGE;
			ST_EDGE: state_d = ST_AREA;
			ST_AREA: state_d = ST_RD;
			ST_RD:   state_d = (k_q < kept_cnt_q) ? ST_LD : ST_DONE;
			ST_LD:   state_d = ST_OV;
			ST_OV:   state_d = ST_IN;
			ST_IN:   state_d = ST_AK;
			ST_AK:   state_d = ST_U;
			ST_U:    state_d = ST_PL;
			ST_PL:   state_d = ST_PH;
			ST_PH:   state_d = suppress ? ST_DONE : ST_RD;
			ST_DONE: state_d = ST_EMIT;
			ST_EMIT: state_d = slot_free ? ST_IDLE : ST_EMIT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && rec.group)
				kept_cnt_q <= '0;
			else if (ram_we)
				kept_cnt_q <= kept_cnt_q + 1'b1;
			if (state_q == ST_EMIT && slot_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= ma * mb;
		unique case (state_q)
			ST_IDLE: begin
				rec_q  <= rec;
				pick_q <= 1'b1;
				full_q <= 1'b0;
			end
			ST_CONF: score_q <= (sh > 48'd65536) ? 17'd65536 : sh[16:0];
			ST_MX:   cx_q <= sat32(mul_q >>> 16);
			ST_MY:   cy_q <= sat32(mul_q >>> 16);
			ST_MW:   w_q  <= sat32(mul_q >>> 16);
			ST_MH:   h_q  <= sat32(mul_q >>> 16);
			ST_EDGE: begin
				l_q <= sat32({{34{le[33]}}, le});
				t_q <= sat32({{34{te[33]}}, te});
			end
			ST_AREA: begin
				aw_q <= mul_q[63:0];
				k_q  <= '0;
			end
			ST_LD: begin
				ox_q  <= (dfx > 34'sd0) ? dfx[32:0] : '0;
				oy_q  <= (dfy > 34'sd0) ? dfy[32:0] : '0;
				kwc_q <= kw[31] ? '0 : kw[30:0];
				khc_q <= kh[31] ? '0 : kh[30:0];
			end
			ST_IN:   inter_q <= mul_q[63:0];
			ST_AK:   uni_q <= aw_q + mul_q[63:0] - inter_q;
			ST_PL:   plo_q <= mul_q[48:0];
			ST_PH: begin
				if (suppress)
					pick_q <= 1'b0;
				k_q <= k_q + 1'b1;
			end
			ST_DONE: begin
				if (pick_q && !room)
					full_q <= 1'b1;
			end
			ST_EMIT: begin
				if (slot_free) begin
					out_q.left_x        <= l_q;
					out_q.top_y         <= t_q;
					out_q.center_x      <= cx_q;
					out_q.center_y      <= cy_q;
					out_q.box_width     <= w_q;
					out_q.box_height    <= h_q;
					out_q.score         <= score_q;
					out_q.picked        <= pick_q;
					out_q.store_full    <= full_q;
					out_q.source_camera <= cfg.camera_id;
					if (cfg.class_count == 8'(BASKET_CLASSES)) begin
						out_q.in_basket   <= rec_q.best_class[0];
						out_q.class_label <= {1'b0, rec_q.best_class[7:1]};
					end else begin
						out_q.in_basket   <= 1'b0;
						out_q.class_label <= rec_q.best_class;
					end
				end
			end
			default: begin
			end
		endcase
	end

	`DGNMS_ASSERT_ALWAYS(a_kept_bound, kept_cnt_q <= CW'(KEPT_DEPTH))
	`DGNMS_ASSERT_IMPLIES(a_walk_in_range, state_q == ST_LD, k_q < kept_cnt_q)
	`DGNMS_ASSERT_IMPLIES(a_full_needs_pick, out_valid_q, !out_q.store_full || out_q.picked)

endmodule

// ----- dv/tb.sv -----
module tb import dgnms_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	class nms_scoreboard;
		cfg_t regs;
		int row_pos;
		longint row_box[4];
		longint objectness, best;
		int best_cls;
		longint kept_l[KEPT_DEPTH_DEF], kept_w[KEPT_DEPTH_DEF];
		longint kept_t[KEPT_DEPTH_DEF], kept_h[KEPT_DEPTH_DEF];
		int kept;
		out_item_t due[$];
		int errors;

		function new();
			regs = '{class_count: 80, min_objectness: 26214, min_confidence: 32768,
				max_overlap: 26214, pad_x: 0, pad_y: 0, inverse_scale: 65536, camera_id: 0};
			row_pos = 0;
			kept = 0;
			best_cls = 0;
			errors = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_W-1:0] v);
			case (idx)
				CFG_CLASS_COUNT: regs.class_count = v[7:0];
				CFG_MIN_OBJECTNESS: regs.min_objectness = v[16:0];
				CFG_MIN_CONFIDENCE: regs.min_confidence = v[16:0];
				CFG_MAX_OVERLAP: regs.max_overlap = v[16:0];
				CFG_PAD_X: regs.pad_x = v[11:0];
				CFG_PAD_Y: regs.pad_y = v[11:0];
				CFG_INVERSE_SCALE: regs.inverse_scale = v[23:0];
				CFG_CAMERA_ID: regs.camera_id = v[3:0];
				default: ;
			endcase
		endfunction

		function int classes();
			int n;
			n = regs.class_count;
			if (n == 0) n = 1;
			if (n > MAX_CLASSES) n = MAX_CLASSES;
			return n;
		endfunction

		function longint clip32(longint v);
			if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
			if (v < -64'sh8000_0000) return -64'sh8000_0000;
			return v;
		endfunction

		function longint to_image(longint v, longint pad);
			longint d;
			d = v - (pad <<< 16);
			return clip32((d * longint'(regs.inverse_scale)) >>> 16);
		endfunction

		function longint unsigned span(longint l1, longint w1, longint l2, longint w2);
			longint lo, hi;
			lo = (l1 > l2) ? l1 : l2;
			hi = (l1 + w1 < l2 + w2) ? l1 + w1 : l2 + w2;
			return (hi > lo) ? longint'(hi - lo) : 0;
		endfunction

		function longint unsigned area(longint w, longint h);
			longint unsigned a, b;
			a = (w > 0) ? w : 0;
			b = (h > 0) ? h : 0;
			return a * b;
		endfunction

		function bit suppressed(longint l, longint t, longint w, longint h, int k);
			longint unsigned inter, uni;
			logic [127:0] lhs, rhs;
			inter = span(l, w, kept_l[k], kept_w[k]) * span(t, h, kept_t[k], kept_h[k]);
			uni = area(w, h) + area(kept_w[k], kept_h[k]) - inter;
			lhs = 128'(inter) * 128'd65536;
			rhs = 128'(uni) * 128'(regs.max_overlap);
			return lhs > rhs;
		endfunction

		function void note_element(in_item_t it);
			longint e, product, cx, cy, w, h, l, t;
			longint unsigned score;
			int pos, n, label;
			bit basket, pick, full;
			out_item_t r;
			e = longint'($signed(it.element));
			n = classes();
			if (it.group_start) begin
				row_pos = 0;
				kept = 0;
			end
			pos = row_pos;
			if (pos < 4) row_box[pos] = e;
			else if (pos == 4) objectness = e;
			else if (pos == BOX_FIELDS) begin
				best = e;
				best_cls = 0;
			end else if (e > best) begin
				best = e;
				best_cls = pos - BOX_FIELDS;
			end
			if (pos < BOX_FIELDS - 1 + n) begin
				row_pos = pos + 1;
				return;
			end
			row_pos = 0;
			if (objectness < longint'(regs.min_objectness)) return;
			product = objectness * best;
			if (product < (longint'(regs.min_confidence) <<< 16)) return;
			score = product >> 16;
			if (score > 65536) score = 65536;
			label = best_cls;
			basket = 0;
			if (n == BASKET_CLASSES) begin
				basket = label[0];
				label = label >> 1;
			end
			cx = to_image(row_box[0], longint'(regs.pad_x));
			cy = to_image(row_box[1], longint'(regs.pad_y));
			w = to_image(row_box[2], 0);
			h = to_image(row_box[3], 0);
			l = clip32(cx - (w >>> 1));
			t = clip32(cy - (h >>> 1));
			pick = 1;
			full = 0;
			for (int k = 0; k < kept; k++)
				if (suppressed(l, t, w, h, k)) pick = 0;
			if (pick) begin
				if (kept < KEPT_DEPTH_DEF) begin
					kept_l[kept] = l;
					kept_w[kept] = w;
					kept_t[kept] = t;
					kept_h[kept] = h;
					kept++;
				end else begin
					full = 1;
				end
			end
			r.left_x = l[31:0];
			r.top_y = t[31:0];
			r.center_x = cx[31:0];
			r.center_y = cy[31:0];
			r.box_width = w[31:0];
			r.box_height = h[31:0];
			r.class_label = label[7:0];
			r.score = score[16:0];
			r.in_basket = basket;
			r.picked = pick;
			r.store_full = full;
			r.source_camera = regs.camera_id;
			due = {due, r};
		endfunction

		function void compare(string field, longint e, longint a);
			if (e != a) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, a);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (due.size() == 0) begin
				$display("%0t: unexpected result, actual %0h", $time, got);
				errors++;
				return;
			end
			e = due.pop_front();
			compare("left_x", e.left_x, got.left_x);
			compare("top_y", e.top_y, got.top_y);
			compare("center_x", e.center_x, got.center_x);
			compare("center_y", e.center_y, got.center_y);
			compare("box_width", e.box_width, got.box_width);
			compare("box_height", e.box_height, got.box_height);
			compare("class_label", e.class_label, got.class_label);
			compare("score", e.score, got.score);
			compare("in_basket", e.in_basket, got.in_basket);
			compare("picked", e.picked, got.picked);
			compare("store_full", e.store_full, got.store_full);
			compare("source_camera", e.source_camera, got.source_camera);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_we;
	in_item_t in_data;
	out_item_t out_data;
	logic [2:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	nms_scoreboard sb = new();
	bit calm = 0;
	int sent = 0;
	int quiet = 0;

	detection_decode_greedy_nms uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we)
				sb.set_reg(cfg_idx_t'(cfg_index), cfg_data);
			if (in_valid && in_ready)
				sb.note_element(in_data);
			if (out_valid && out_ready)
				sb.check_result(out_data);
			if (cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet > 20000) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		int hold;
		hold = 0;
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0)
				hold--;
			else if (!calm && $urandom_range(0, 6) == 0) begin
				out_ready <= 1'b0;
				hold = $urandom_range(0, 8);
			end else
				out_ready <= 1'b1;
		end
	end

	task automatic send(logic [31:0] v, logic gs);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{element: v, group_start: gs};
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(negedge clk);
		repeat (700) @(negedge clk);
	endtask

	task automatic load_regs(cfg_t c);
		logic [CFG_W-1:0] vals[8];
		vals = '{CFG_W'(c.class_count), CFG_W'(c.min_objectness), CFG_W'(c.min_confidence),
			CFG_W'(c.max_overlap), CFG_W'(c.pad_x), CFG_W'(c.pad_y), c.inverse_scale,
			CFG_W'(c.camera_id)};
		settle();
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_idx_t'(i);
			cfg_data <= vals[i];
			@(negedge clk);
		end
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] row_value(int pos);
		if ($urandom_range(0, 19) == 0) return $urandom;
		if (pos < 2) return ($urandom_range(0, 300) << 16) | $urandom_range(0, 65535);
		if (pos < 4) begin
			if ($urandom_range(0, 15) == 0) return -($urandom_range(0, 100) << 16);
			return ($urandom_range(0, 150) << 16) | $urandom_range(0, 65535);
		end
		if ($urandom_range(0, 3) == 0) return 40000 + 10000 * $urandom_range(0, 2);
		return $urandom_range(0, 70000);
	endfunction

	task automatic send_row(logic gs, bit broken);
		int n;
		n = BOX_FIELDS + sb.classes();
		if (broken) n = $urandom_range(1, n - 1);
		for (int i = 0; i < n; i++) send(row_value(i), gs && i == 0);
	endtask

	function automatic logic [16:0] q16(int low_bias);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 17'd0;
		if (r == 1) return 17'd65536;
		return 17'($urandom_range(0, low_bias));
	endfunction

	initial begin
		cfg_t c;
		int n, budget, pick;
		int counts[10] = '{0, 1, 2, 3, 4, 7, 7, 250, 255, 80};
		arst_n = 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_CLASS_COUNT;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		c = '{class_count: 1, min_objectness: 0, min_confidence: 0, max_overlap: 26214,
			pad_x: 0, pad_y: 0, inverse_scale: 65536, camera_id: 15};
		load_regs(c);
		for (int r = 0; r < 2; r++)
			for (int i = 0; i < 6; i++) send(32'h0, r == 0 && i == 0);
		send(32'h7FFF_FFFF, 0);
		send(32'h8000_0000, 0);
		send(32'h7FFF_FFFF, 0);
		send(32'h8000_0000, 0);
		send(32'h7FFF_FFFF, 0);
		send(32'h7FFF_FFFF, 0);
		send(32'h0010_0000, 0);
		send(32'hFFFF_FFFF, 0);
		send_row(1, 0);

		c = '{class_count: 1, min_objectness: 0, min_confidence: 0, max_overlap: 65536,
			pad_x: 4095, pad_y: 4095, inverse_scale: 24'hFFFFFF, camera_id: 0};
		load_regs(c);
		for (int r = 0; r < 70; r++) send_row(r == 0, 0);

		while (sent < 1060) begin
			c.class_count = 8'(counts[$urandom_range(0, 9)]);
			c.min_objectness = q16(40000);
			c.min_confidence = q16(30000);
			c.max_overlap = q16(65536);
			pick = $urandom_range(0, 9);
			c.pad_x = (pick == 0) ? 12'd4095 : (pick < 3) ? 12'd0 : 12'($urandom_range(0, 100));
			c.pad_y = (pick == 1) ? 12'd4095 : (pick < 4) ? 12'd0 : 12'($urandom_range(0, 100));
			c.inverse_scale = (pick == 2) ? 24'd0 : (pick == 3) ? 24'hFFFFFF
				: 24'($urandom_range(32768, 131072));
			c.camera_id = 4'($urandom_range(0, 15));
			if (sent > 960) calm = 1;
			load_regs(c);
			budget = sent + 90;
			n = 0;
			do begin
				if (!calm && $urandom_range(0, 9) == 0) send_row(1, 1);
				send_row(n == 0 || $urandom_range(0, 9) == 0, 0);
				n++;
			end while (sent < budget && sb.classes() < 100);
		end

		settle();
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/dgnms_pkg.sv
rtl/dgnms_ram.sv
rtl/dgnms_queue.sv
rtl/dgnms_front.sv
rtl/dgnms_back.sv
rtl/detection_decode_greedy_nms.sv
dv/tb.sv
